// File: hw/rtl/tks_pkg.sv
package tks_pkg;

	typedef enum logic [1:0] {
		OP_DATA    = 2'd0,
		OP_FINAL   = 2'd1,
		OP_END     = 2'd2,
		OP_RESTART = 2'd3
	} op_e;

	typedef enum logic [2:0] {
		KIND_NUMBER = 3'd0,
		KIND_STRING = 3'd1,
		KIND_IDENT  = 3'd2,
		KIND_OPER   = 3'd3,
		KIND_EOF    = 3'd4,
		KIND_ERROR  = 3'd5
	} kind_e;

	typedef enum logic [1:0] {
		ERR_NONE       = 2'd0,
		ERR_NUM_ALPHA  = 2'd1,
		ERR_OPEN_STR   = 2'd2,
		ERR_BAD_BYTE   = 2'd3
	} err_e;

	localparam int FW      = 17;
	localparam int RES_MAX = 3;
	localparam int RES_CW  = 2;
	localparam int QDEPTH  = 4;
	localparam int QAW     = 2;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] byte_value;
	} tok_in_t;

	typedef struct packed {
		logic [2:0]    token_kind;
		logic [1:0]    error_code;
		logic [FW-1:0] start_offset;
		logic [FW-1:0] start_row;
		logic [FW-1:0] start_column;
		logic [FW-1:0] value_length;
		logic          last_of_run;
	} tok_out_t;

	// All results caused by one request, oldest in slot 0
	typedef struct packed {
		logic [RES_CW-1:0]            cnt;
		tok_out_t [RES_MAX-1:0]       res;
	} bundle_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

endpackage

// File: hw/rtl/ascii_token_scanner_core.sv
// Results of an accepted request go into the result queue, then out through a registered output.
// Throughput: one request per cycle while each gives at most one result and the output is
// not stalled; a request that closes tokens gives up to three results, drained one per cycle
// while tok_stall is low from a four-entry result queue, and requests stall only when that queue is full.
// Reset (arst_n low, asynchronous): scanner idle at offset 0, line 1, column 1;
// queue and output empty.
module ascii_token_scanner_core import tks_pkg::*; #(
	parameter longint unsigned MAX_INPUT_BYTES = 65536
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     src_valid,
	output logic     src_stall,
	input  tok_in_t  src_data,
	output logic     tok_valid,
	input  logic     tok_stall,
	output tok_out_t tok_data
);

	logic    push;
	bundle_t push_data;
	logic    pop;
	bundle_t head;
	q_stat_t q_stat;

	tks_front #(
		.MAX_INPUT_BYTES(MAX_INPUT_BYTES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.src_data (src_data),
		.q_stat   (q_stat),
		.push     (push),
		.push_data(push_data)
	);

	tks_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	tks_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_stat   (q_stat),
		.pop      (pop),
		.tok_valid(tok_valid),
		.tok_stall(tok_stall),
		.tok_data (tok_data)
	);

endmodule

// File: hw/rtl/tks_front.sv
module tks_front import tks_pkg::*; #(
	parameter longint unsigned MAX_INPUT_BYTES = 65536
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    src_valid,
	output logic    src_stall,
	input  tok_in_t src_data,
	input  q_stat_t q_stat,
	output logic    push,
	output bundle_t push_data
);

	localparam int CW = $clog2(MAX_INPUT_BYTES + 1);
	localparam logic [CW-1:0] SAT = CW'(MAX_INPUT_BYTES);

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF  = 8'h0a;
	localparam logic [7:0] CH_CR  = 8'h0d;
	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_DQ  = 8'h22;
	localparam logic [7:0] CH_US  = 8'h5f;

	typedef enum logic [2:0] {
		M_IDLE, M_NUMBER, M_STRING, M_IDENT, M_OPER, M_EOF, M_ERROR
	} mode_e;

	typedef logic [CW-1:0] cnt_t;

	typedef struct packed {
		mode_e mode;
		cnt_t  off;
		cnt_t  ln;
		cnt_t  col;
		cnt_t  toff;
		cnt_t  tln;
		cnt_t  tcol;
		cnt_t  run;
		logic  cr;
	} scan_t;

	localparam scan_t SCAN_RST = '{
		mode: M_IDLE, off: '0, ln: cnt_t'(1), col: cnt_t'(1),
		toff: '0, tln: cnt_t'(1), tcol: cnt_t'(1), run: '0, cr: 1'b0
	};

	function automatic cnt_t sat_inc(cnt_t v);
		return (v >= SAT) ? SAT : cnt_t'(v + 1'b1);
	endfunction

	function automatic scan_t adv(scan_t s);
		s.off = sat_inc(s.off);
		s.col = sat_inc(s.col);
		return s;
	endfunction

	function automatic scan_t ext(scan_t s);
		s.run = sat_inc(s.run);
		return adv(s);
	endfunction

	function automatic tok_out_t mk(kind_e k, err_e e, cnt_t o, cnt_t l, cnt_t c, cnt_t n);
		tok_out_t r;
		r.token_kind   = k;
		r.error_code   = e;
		r.start_offset = FW'(o);
		r.start_row    = FW'(l);
		r.start_column = FW'(c);
		r.value_length = FW'(n);
		r.last_of_run  = 1'b0;
		return r;
	endfunction

	function automatic logic is_digit(logic [7:0] b);
		return b inside {[8'h30:8'h39]};
	endfunction

	function automatic logic is_id_start(logic [7:0] b);
		return b inside {[8'h41:8'h5a], [8'h61:8'h7a], CH_US};
	endfunction

	function automatic logic is_symbol(logic [7:0] b);
		return !(b inside {CH_NUL, CH_SP, CH_TAB, CH_LF, CH_CR, CH_DQ})
			&& !is_id_start(b) && !is_digit(b);
	endfunction

	scan_t                  st_q;
	scan_t                  nx;
	tok_out_t [RES_MAX-1:0] res;
	logic [RES_CW-1:0]      n;
	logic                   rescan;
	logic                   cr_prev;
	logic [7:0]             b;
	logic                   accept;

	assign src_stall = q_stat.full;
	assign accept    = src_valid && !src_stall;

	always_comb begin
		nx      = st_q;
		res     = '0;
		n       = '0;
		rescan  = 1'b0;
		cr_prev = 1'b0;
		b       = src_data.byte_value;
		if (src_data.opcode == OP_RESTART) begin
			nx = SCAN_RST;
		end else if (st_q.mode != M_EOF && st_q.mode != M_ERROR) begin
			if (src_data.opcode == OP_DATA || src_data.opcode == OP_FINAL) begin
				case (nx.mode)
					M_IDLE: begin
						rescan = 1'b1;
					end
					M_NUMBER: begin
						nx.cr = 1'b0;
						if (is_digit(b)) begin
							nx = ext(nx);
						end else if (is_id_start(b)) begin
							res[n]  = mk(KIND_ERROR, ERR_NUM_ALPHA, nx.toff, nx.tln, nx.tcol, '0);
							n       = n + 1'b1;
							nx.mode = M_ERROR;
						end else begin
							res[n]  = mk(KIND_NUMBER, ERR_NONE, nx.toff, nx.tln, nx.tcol, nx.run);
							n       = n + 1'b1;
							nx.mode = M_IDLE;
							rescan  = 1'b1;
						end
					end
					M_STRING: begin
						nx.cr = 1'b0;
						if (b == CH_DQ) begin
							res[n]  = mk(KIND_STRING, ERR_NONE, nx.toff, nx.tln, nx.tcol, nx.run);
							n       = n + 1'b1;
							nx.mode = M_IDLE;
							nx      = adv(nx);
						end else if (b == CH_LF || b == CH_CR) begin
							res[n]  = mk(KIND_ERROR, ERR_OPEN_STR, nx.toff, nx.tln, nx.tcol, '0);
							n       = n + 1'b1;
							nx.mode = M_ERROR;
						end else if (b == CH_NUL) begin
							res[n]  = mk(KIND_ERROR, ERR_BAD_BYTE, nx.off, nx.ln, nx.col, '0);
							n       = n + 1'b1;
							nx.mode = M_ERROR;
						end else begin
							nx = ext(nx);
						end
					end
					M_IDENT: begin
						nx.cr = 1'b0;
						if (is_id_start(b) || is_digit(b)) begin
							nx = ext(nx);
						end else begin
							res[n]  = mk(KIND_IDENT, ERR_NONE, nx.toff, nx.tln, nx.tcol, nx.run);
							n       = n + 1'b1;
							nx.mode = M_IDLE;
							rescan  = 1'b1;
						end
					end
					M_OPER: begin
						nx.cr = 1'b0;
						if (is_symbol(b)) begin
							nx = ext(nx);
						end else begin
							res[n]  = mk(KIND_OPER, ERR_NONE, nx.toff, nx.tln, nx.tcol, nx.run);
							n       = n + 1'b1;
							nx.mode = M_IDLE;
							rescan  = 1'b1;
						end
					end
					default: begin
					end
				endcase
				// Scan the byte again from idle: a byte met in idle mode, or one that closed a token
				if (rescan) begin
					cr_prev = nx.cr;
					nx.cr   = 1'b0;
					if (cr_prev && b == CH_LF) begin
						nx.off = sat_inc(nx.off);
					end else if (b == CH_SP || b == CH_TAB) begin
						nx = adv(nx);
					end else if (b == CH_LF || b == CH_CR) begin
						nx.off = sat_inc(nx.off);
						nx.ln  = sat_inc(nx.ln);
						nx.col = cnt_t'(1);
						nx.cr  = (b == CH_CR);
					end else if (b == CH_NUL) begin
						res[n]  = mk(KIND_ERROR, ERR_BAD_BYTE, nx.off, nx.ln, nx.col, '0);
						n       = n + 1'b1;
						nx.mode = M_ERROR;
					end else begin
						nx.toff = nx.off;
						nx.tln  = nx.ln;
						nx.tcol = nx.col;
						nx      = adv(nx);
						if (b == CH_DQ) begin
							nx.mode = M_STRING;
							nx.run  = '0;
						end else begin
							nx.run = cnt_t'(1);
							if (is_digit(b)) begin
								nx.mode = M_NUMBER;
							end else if (is_id_start(b)) begin
								nx.mode = M_IDENT;
							end else begin
								nx.mode = M_OPER;
							end
						end
					end
				end
			end
			if ((src_data.opcode == OP_FINAL || src_data.opcode == OP_END)
					&& nx.mode != M_ERROR) begin
				if (nx.mode == M_STRING) begin
					res[n]  = mk(KIND_ERROR, ERR_OPEN_STR, nx.toff, nx.tln, nx.tcol, '0);
					n       = n + 1'b1;
					nx.mode = M_ERROR;
				end else begin
					if (nx.mode == M_NUMBER) begin
						res[n]  = mk(KIND_NUMBER, ERR_NONE, nx.toff, nx.tln, nx.tcol, nx.run);
						n       = n + 1'b1;
						nx.mode = M_IDLE;
					end else if (nx.mode == M_IDENT) begin
						res[n]  = mk(KIND_IDENT, ERR_NONE, nx.toff, nx.tln, nx.tcol, nx.run);
						n       = n + 1'b1;
						nx.mode = M_IDLE;
					end else if (nx.mode == M_OPER) begin
						res[n]  = mk(KIND_OPER, ERR_NONE, nx.toff, nx.tln, nx.tcol, nx.run);
						n       = n + 1'b1;
						nx.mode = M_IDLE;
					end
					if (nx.mode == M_IDLE) begin
						res[n]  = mk(KIND_EOF, ERR_NONE, nx.off, nx.ln, nx.col, '0);
						n       = n + 1'b1;
						nx.mode = M_EOF;
					end
				end
			end
		end
	end

	assign push          = accept && (n != '0);
	assign push_data.cnt = n;
	assign push_data.res = res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= SCAN_RST;
		end else if (accept) begin
			st_q <= nx;
		end
	end

endmodule

// File: hw/rtl/tks_queue.sv
module tks_queue import tks_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  bundle_t push_data,
	input  logic    pop,
	output bundle_t head,
	output q_stat_t q_stat
);

	bundle_t        mem [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   cnt_q;

	assign head         = mem[rd_ptr_q];
	assign q_stat.empty = (cnt_q == '0);
	assign q_stat.full  = (cnt_q == (QAW + 1)'(QDEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: hw/rtl/tks_back.sv
module tks_back import tks_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  bundle_t  head,
	input  q_stat_t  q_stat,
	output logic     pop,
	output logic     tok_valid,
	input  logic     tok_stall,
	output tok_out_t tok_data
);

	logic [RES_CW-1:0] sub_q;
	logic              load;
	logic              last;
	tok_out_t          head_tok;

	assign load = !q_stat.empty && (!tok_valid || !tok_stall);
	assign last = (sub_q == RES_CW'(head.cnt - 1'b1));
	// Release the queue entry with its final result
	assign pop  = load && last;

	always_comb begin
		head_tok             = head.res[sub_q];
		head_tok.last_of_run = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_valid <= 1'b0;
			sub_q     <= '0;
		end else if (load) begin
			tok_valid <= 1'b1;
			sub_q     <= last ? '0 : RES_CW'(sub_q + 1'b1);
		end else if (!tok_stall) begin
			tok_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			tok_data <= head_tok;
		end
	end

endmodule

// File: hw/rtl/tks_checker.sv
module tks_checker import tks_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     tok_valid,
	input logic     tok_stall,
	input tok_out_t tok_data
);

	logic final_kind;

	assign final_kind = (tok_data.token_kind == KIND_EOF) || (tok_data.token_kind == KIND_ERROR);

	// Hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && tok_stall |=> tok_valid && $stable(tok_data))
		else $error("stalled result changed");

	// End of file and error close the request that caused them
	a_final_last: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && final_kind |-> tok_data.last_of_run)
		else $error("end of file or error not last of run");

	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid |-> ((tok_data.token_kind == KIND_ERROR) == (tok_data.error_code != ERR_NONE)))
		else $error("error code does not match kind");

	a_no_len: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && final_kind |-> (tok_data.value_length == '0))
		else $error("nonzero length on end of file or error");

endmodule

bind ascii_token_scanner_core tks_checker u_chk (.*);

// File: tb/tb.sv
module tb;
	import tks_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT = 800000;
	localparam logic [FW-1:0] POS_CAP = 17'd65536;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_US    = 8'h5F;

	typedef enum logic [2:0] {
		SM_IDLE,
		SM_NUMBER,
		SM_STRING,
		SM_IDENT,
		SM_OPER,
		SM_EOF,
		SM_ERROR
	} scan_state_e;

	typedef struct packed {
		op_e        op;
		logic [7:0] b;
		bit         typed;
		tok_out_t   res;
	} drill_row_t;

	localparam tok_out_t NO_RES = '0;

	// Typed rows hold the one result that request must give
	localparam drill_row_t DRILL [26] = '{
		'{OP_END,     8'h00,    1'b1, '{KIND_EOF, ERR_NONE, 17'd0, 17'd1, 17'd1, 17'd0, 1'b1}},
		'{OP_DATA,    "a",      1'b0, NO_RES},
		'{OP_RESTART, 8'h00,    1'b0, NO_RES},
		'{OP_DATA,    "9",      1'b0, NO_RES},
		'{OP_DATA,    "Z",      1'b1,
			'{KIND_ERROR, ERR_NUM_ALPHA, 17'd0, 17'd1, 17'd1, 17'd0, 1'b1}},
		'{OP_RESTART, 8'hFF,    1'b0, NO_RES},
		'{OP_DATA,    CH_NUL,   1'b1,
			'{KIND_ERROR, ERR_BAD_BYTE, 17'd0, 17'd1, 17'd1, 17'd0, 1'b1}},
		'{OP_RESTART, 8'h00,    1'b0, NO_RES},
		'{OP_DATA,    CH_QUOTE, 1'b0, NO_RES},
		'{OP_DATA,    8'hFF,    1'b0, NO_RES},
		'{OP_DATA,    CH_CR,    1'b1,
			'{KIND_ERROR, ERR_OPEN_STR, 17'd0, 17'd1, 17'd1, 17'd0, 1'b1}},
		'{OP_RESTART, 8'h55,    1'b0, NO_RES},
		'{OP_DATA,    CH_US,    1'b0, NO_RES},
		'{OP_DATA,    CH_CR,    1'b0, NO_RES},
		'{OP_DATA,    CH_LF,    1'b0, NO_RES},
		'{OP_DATA,    8'hFF,    1'b0, NO_RES},
		'{OP_DATA,    CH_QUOTE, 1'b0, NO_RES},
		'{OP_DATA,    "q",      1'b0, NO_RES},
		'{OP_DATA,    CH_QUOTE, 1'b0, NO_RES},
		'{OP_DATA,    CH_TAB,   1'b0, NO_RES},
		'{OP_DATA,    "7",      1'b0, NO_RES},
		'{OP_FINAL,   ")",      1'b0, NO_RES},
		'{OP_DATA,    "x",      1'b0, NO_RES},
		'{OP_RESTART, 8'hAA,    1'b0, NO_RES},
		'{OP_FINAL,   CH_QUOTE, 1'b1,
			'{KIND_ERROR, ERR_OPEN_STR, 17'd0, 17'd1, 17'd1, 17'd0, 1'b1}},
		'{OP_RESTART, 8'h00,    1'b0, NO_RES}
	};

	localparam int SRC_IDLE_PCT [4] = '{0, 87, 0, 31};
	localparam int RCV_STALL_PCT [4] = '{0, 0, 87, 31};

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     src_valid = 1'b0;
	logic     src_stall;
	tok_in_t  src_data = '0;
	logic     tok_valid;
	logic     tok_stall = 1'b0;
	tok_out_t tok_data;

	int unsigned cycles = 0;
	int          bad_count = 0;
	int          src_idle_pct = 0;
	int          rcv_stall_pct = 0;
	bit          cur_typed = 1'b0;
	tok_out_t    cur_typed_res = '0;

	tok_in_t  source_reqs [$];
	tok_out_t pending_tokens [$];
	tok_out_t step_tokens [$];

	// scanner state mirror
	scan_state_e   sm;
	logic [FW-1:0] at_offset, at_line, at_column;
	logic [FW-1:0] tok_offset, tok_line, tok_column, tok_len;
	bit            after_cr;

	ascii_token_scanner_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_data  (src_data),
		.tok_valid (tok_valid),
		.tok_stall (tok_stall),
		.tok_data  (tok_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("** ascii_token_scanner_core: FAILED **");
			$finish;
		end
	end

	always @(negedge clk) begin
		tok_stall <= (rcv_stall_pct != 0) && ($urandom_range(0, 99) < rcv_stall_pct);
	end

	function automatic logic [FW-1:0] sat_bump(logic [FW-1:0] v);
		return (v >= POS_CAP) ? POS_CAP : FW'(v + 1'b1);
	endfunction

	function automatic bit is_digit(logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	function automatic bit is_word_start(logic [7:0] b);
		return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == CH_US;
	endfunction

	function automatic bit is_word_char(logic [7:0] b);
		return is_word_start(b) || is_digit(b);
	endfunction

	function automatic bit is_symbol(logic [7:0] b);
		return b != CH_NUL && b != CH_SP && b != CH_TAB && b != CH_LF && b != CH_CR
			&& !is_word_char(b) && b != CH_QUOTE;
	endfunction

	function automatic void post(kind_e k, err_e e, logic [FW-1:0] off, logic [FW-1:0] ln,
			logic [FW-1:0] col, logic [FW-1:0] len);
		tok_out_t t;
		t.token_kind = k;
		t.error_code = e;
		t.start_offset = off;
		t.start_row = ln;
		t.start_column = col;
		t.value_length = len;
		t.last_of_run = 1'b0;
		step_tokens.push_back(t);
	endfunction

	function automatic void advance_col();
		at_offset = sat_bump(at_offset);
		at_column = sat_bump(at_column);
	endfunction

	function automatic void extend_token();
		tok_len = sat_bump(tok_len);
		advance_col();
	endfunction

	function automatic void close_token(kind_e k);
		post(k, ERR_NONE, tok_offset, tok_line, tok_column, tok_len);
		sm = SM_IDLE;
	endfunction

	function automatic void fail_at_token(err_e e);
		post(KIND_ERROR, e, tok_offset, tok_line, tok_column, '0);
		sm = SM_ERROR;
	endfunction

	function automatic void fail_here(err_e e);
		post(KIND_ERROR, e, at_offset, at_line, at_column, '0);
		sm = SM_ERROR;
	endfunction

	function automatic void scan_reset();
		sm = SM_IDLE;
		at_offset = '0;
		at_line = 17'd1;
		at_column = 17'd1;
		tok_offset = '0;
		tok_line = 17'd1;
		tok_column = 17'd1;
		tok_len = '0;
		after_cr = 1'b0;
	endfunction

	function automatic void scan_fresh(logic [7:0] b);
		bit cr;
		cr = after_cr;
		after_cr = 1'b0;
		if (cr && b == CH_LF) begin
			// LF right after CR belongs to the same newline
			at_offset = sat_bump(at_offset);
		end else if (b == CH_SP || b == CH_TAB) begin
			advance_col();
		end else if (b == CH_LF || b == CH_CR) begin
			at_offset = sat_bump(at_offset);
			at_line = sat_bump(at_line);
			at_column = 17'd1;
			after_cr = (b == CH_CR);
		end else if (b == CH_NUL) begin
			fail_here(ERR_BAD_BYTE);
		end else begin
			tok_offset = at_offset;
			tok_line = at_line;
			tok_column = at_column;
			advance_col();
			if (b == CH_QUOTE) begin
				sm = SM_STRING;
				tok_len = '0;
			end else begin
				tok_len = 17'd1;
				sm = is_digit(b) ? SM_NUMBER : is_word_start(b) ? SM_IDENT : SM_OPER;
			end
		end
	endfunction

	function automatic void scan_byte(logic [7:0] b);
		case (sm)
			SM_IDLE: scan_fresh(b);
			SM_NUMBER: begin
				after_cr = 1'b0;
				if (is_digit(b)) extend_token();
				else if (is_word_start(b)) fail_at_token(ERR_NUM_ALPHA);
				else begin
					close_token(KIND_NUMBER);
					scan_fresh(b);
				end
			end
			SM_STRING: begin
				after_cr = 1'b0;
				if (b == CH_QUOTE) begin
					close_token(KIND_STRING);
					advance_col();
				end else if (b == CH_LF || b == CH_CR) begin
					fail_at_token(ERR_OPEN_STR);
				end else if (b == CH_NUL) begin
					fail_here(ERR_BAD_BYTE);
				end else begin
					extend_token();
				end
			end
			SM_IDENT: begin
				after_cr = 1'b0;
				if (is_word_char(b)) extend_token();
				else begin
					close_token(KIND_IDENT);
					scan_fresh(b);
				end
			end
			SM_OPER: begin
				after_cr = 1'b0;
				if (is_symbol(b)) extend_token();
				else begin
					close_token(KIND_OPER);
					scan_fresh(b);
				end
			end
			default: ;
		endcase
	endfunction

	function automatic void scan_end();
		if (sm == SM_STRING) begin
			fail_at_token(ERR_OPEN_STR);
		end else begin
			case (sm)
				SM_NUMBER: close_token(KIND_NUMBER);
				SM_IDENT:  close_token(KIND_IDENT);
				SM_OPER:   close_token(KIND_OPER);
				default: ;
			endcase
			if (sm == SM_IDLE) begin
				post(KIND_EOF, ERR_NONE, at_offset, at_line, at_column, '0);
				sm = SM_EOF;
			end
		end
	endfunction

	function automatic void scan_request(tok_in_t r);
		step_tokens.delete();
		if (r.opcode == OP_RESTART) begin
			scan_reset();
		end else if (sm != SM_EOF && sm != SM_ERROR) begin
			if (r.opcode == OP_DATA || r.opcode == OP_FINAL) scan_byte(r.byte_value);
			if ((r.opcode == OP_FINAL || r.opcode == OP_END) && sm != SM_ERROR) scan_end();
			if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last_of_run = 1'b1;
		end
	endfunction

	function automatic void field_check(string name, logic [FW-1:0] want, logic [FW-1:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			bad_count++;
		end
	endfunction

	function automatic void check_token(tok_out_t got);
		tok_out_t want;
		if (pending_tokens.size() == 0) begin
			$error("token with nothing pending: kind %0d offset %0d",
				got.token_kind, got.start_offset);
			bad_count++;
		end else begin
			want = pending_tokens.pop_front();
			field_check("token_kind", FW'(want.token_kind), FW'(got.token_kind));
			field_check("error_code", FW'(want.error_code), FW'(got.error_code));
			field_check("start_offset", want.start_offset, got.start_offset);
			field_check("start_row", want.start_row, got.start_row);
			field_check("start_column", want.start_column, got.start_column);
			field_check("value_length", want.value_length, got.value_length);
			field_check("last_of_run", FW'(want.last_of_run), FW'(got.last_of_run));
		end
	endfunction

	// Check results first, then predict for the request taken at this edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (tok_valid && !tok_stall) check_token(tok_data);
			if (src_valid && !src_stall) begin
				scan_request(src_data);
				if (cur_typed) pending_tokens.push_back(cur_typed_res);
				else foreach (step_tokens[i]) pending_tokens.push_back(step_tokens[i]);
			end
		end
	end

	task automatic issue(tok_in_t r, bit typed, tok_out_t tres);
		while (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
			src_valid <= 1'b0;
			@(negedge clk);
		end
		src_valid <= 1'b1;
		src_data <= r;
		cur_typed = typed;
		cur_typed_res = tres;
		@(posedge clk);
		while (src_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic wait_drain();
		src_valid <= 1'b0;
		while (pending_tokens.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic void add(op_e op, logic [7:0] b);
		tok_in_t r;
		r.opcode = op;
		r.byte_value = b;
		source_reqs.push_back(r);
	endfunction

	function automatic logic [7:0] any_symbol();
		logic [7:0] b;
		do b = 8'($urandom_range(1, 255)); while (!is_symbol(b));
		return b;
	endfunction

	function automatic logic [7:0] string_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(1, 255)); while (b == CH_QUOTE || b == CH_LF || b == CH_CR);
		return b;
	endfunction

	function automatic logic [7:0] word_start();
		int r;
		r = $urandom_range(0, 52);
		if (r == 52) return CH_US;
		return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
	endfunction

	function automatic logic [7:0] word_char();
		if ($urandom_range(0, 3) == 0) return 8'(CH_ZERO + $urandom_range(0, 9));
		return word_start();
	endfunction

	function automatic void add_separator();
		case ($urandom_range(0, 4))
			0: add(OP_DATA, CH_SP);
			1: add(OP_DATA, CH_TAB);
			2: add(OP_DATA, CH_LF);
			3: add(OP_DATA, CH_CR);
			default: begin
				add(OP_DATA, CH_CR);
				add(OP_DATA, CH_LF);
			end
		endcase
	endfunction

	function automatic void add_token();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 24) begin
			repeat ($urandom_range(1, 4)) add(OP_DATA, 8'(CH_ZERO + $urandom_range(0, 9)));
		end else if (sel < 48) begin
			add(OP_DATA, word_start());
			repeat ($urandom_range(0, 5)) add(OP_DATA, word_char());
		end else if (sel < 64) begin
			add(OP_DATA, CH_QUOTE);
			repeat ($urandom_range(0, 5)) add(OP_DATA, string_byte());
			// mostly closed strings; break a few with a newline or NUL
			case ($urandom_range(0, 9))
				0: add(OP_DATA, $urandom_range(0, 1) ? CH_LF : CH_CR);
				1: add(OP_DATA, CH_NUL);
				default: add(OP_DATA, CH_QUOTE);
			endcase
		end else if (sel < 84) begin
			repeat ($urandom_range(1, 3)) add(OP_DATA, any_symbol());
		end else if (sel < 92) begin
			add_separator();
		end else if (sel < 96) begin
			add(OP_DATA, 8'($urandom_range(0, 255)));
		end else if ($urandom_range(0, 1) == 0) begin
			add(OP_DATA, 8'(CH_ZERO + $urandom_range(0, 9)));
			add(OP_DATA, word_start());
		end else begin
			add(OP_DATA, CH_NUL);
		end
		if ($urandom_range(0, 3) != 0) add_separator();
	endfunction

	function automatic void add_program();
		add(OP_RESTART, 8'($urandom_range(0, 255)));
		repeat ($urandom_range(2, 8)) add_token();
		case ($urandom_range(0, 9))
			0, 1, 2: add(OP_FINAL, word_char());
			3, 4: add(OP_FINAL, 8'($urandom_range(0, 255)));
			5, 6, 7, 8: add(OP_END, 8'($urandom_range(0, 255)));
			default: ;
		endcase
		// poke after the end; usually ignored
		if ($urandom_range(0, 4) == 0) add(OP_DATA, 8'($urandom_range(0, 255)));
	endfunction

	initial begin
		scan_reset();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (DRILL[i]) begin
			tok_in_t r;
			r.opcode = DRILL[i].op;
			r.byte_value = DRILL[i].b;
			issue(r, DRILL[i].typed, DRILL[i].res);
		end
		wait_drain();

		for (int ph = 0; ph < 4; ph++) begin
			src_idle_pct = SRC_IDLE_PCT[ph];
			rcv_stall_pct = RCV_STALL_PCT[ph];
			source_reqs.delete();
			while (source_reqs.size() < 45) add_program();
			foreach (source_reqs[i]) issue(source_reqs[i], 1'b0, NO_RES);
			// hold the sender until every pending token is back
			wait_drain();
		end

		if (bad_count == 0) begin
			$display("** ascii_token_scanner_core: PASSED **");
		end else begin
			$display("** ascii_token_scanner_core: FAILED **");
		end
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/tks_pkg.sv
hw/rtl/tks_front.sv
hw/rtl/tks_queue.sv
hw/rtl/tks_back.sv
hw/rtl/ascii_token_scanner_core.sv
hw/rtl/tks_checker.sv
tb/tb.sv
